// ----- rtl/pcmfc_pkg.sv -----
// ---------------------------------------------------------------------------
// pcmfc_pkg
// Shared types and constants of the pcm sample format converter.
// ---------------------------------------------------------------------------
package pcmfc_pkg;

   localparam int RAW_WIDTH  = 64;
   localparam int OUT_WIDTH  = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;
   localparam int LATENCY    = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENCODING = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ENDIAN   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE    = 2'd3;

   // encodings
   localparam logic [1:0] ENC_SIGNED   = 2'd0;
   localparam logic [1:0] ENC_UNSIGNED = 2'd1;
   localparam logic [1:0] ENC_FLOAT    = 2'd2;
   localparam logic [1:0] ENC_RESERVED = 2'd3;

   // conversion kind chosen in the first stage
   typedef enum logic [1:0] {
      KIND_INT, KIND_F32, KIND_F64, KIND_ERR
   } kind_type;

   localparam logic [31:0] SIGN_BIT = 32'h8000_0000;
   localparam logic [31:0] F32_INF  = 32'h7F80_0000;
   localparam logic [31:0] F32_QNAN = 32'h7FC0_0000;

endpackage

// ----- rtl/pcmfc_narrow.sv -----
// ---------------------------------------------------------------------------
// pcmfc_narrow
// Two stage double to single narrowing, round to nearest even.
// Stage one classifies and aligns, stage two rounds and packs.
// ---------------------------------------------------------------------------
module pcmfc_narrow (
   input  logic        clock,
   input  logic        en_a,
   input  logic        en_b,
   input  logic [63:0] dbl,
   output logic [31:0] result
);
   import pcmfc_pkg::*;

   typedef enum logic [1:0] { CL_ZERO, CL_INF, CL_NAN, CL_NUM } class_type;

   logic [10:0] exp_w;
   logic [51:0] man_w;
   logic [52:0] sig_w;
   logic [63:0] sig_x;
   logic signed [12:0] fe_w;
   logic [5:0]  sh_w;
   logic        norm_w;
   class_type   cls_w;

   class_type   cls_ff, cls_in;
   logic        sign_ff;
   logic        norm_ff, norm_in;
   logic [7:0]  ebias_ff, ebias_in;
   logic [21:0] pay_ff;
   logic [24:0] q_ff, q_in;
   logic        guard_ff, guard_in;
   logic        sticky_ff, sticky_in;

   // classify and align
   always_comb begin
      exp_w  = dbl[62:52];
      man_w  = dbl[51:0];
      sig_w  = {1'b1, man_w};
      sig_x  = {11'd0, sig_w};
      fe_w   = $signed({2'b00, exp_w}) - 13'sd896;
      norm_w = (fe_w >= 13'sd1);
      sh_w   = 6'd55;
      if (norm_w) sh_w = 6'd29;
      else if (fe_w > -13'sd25) sh_w = 6'(13'sd30 - fe_w);
      if (exp_w == 11'h7FF) cls_w = (man_w == 52'd0) ? CL_INF : CL_NAN;
      else if (exp_w == 11'd0) cls_w = CL_ZERO;
      else if (fe_w >= 13'sd255) cls_w = CL_INF;
      else if (!norm_w && sh_w >= 6'd55) cls_w = CL_ZERO;
      else cls_w = CL_NUM;
      cls_in    = cls_w;
      norm_in   = norm_w;
      ebias_in  = norm_w ? 8'(fe_w - 13'sd1) : 8'd0;
      q_in      = 25'(sig_x >> sh_w);
      guard_in  = sig_x[sh_w-6'd1];
      sticky_in = |(sig_x & ((64'd1 << (sh_w - 6'd1)) - 64'd1));
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         cls_ff    <= cls_in;
         sign_ff   <= dbl[63];
         norm_ff   <= norm_in;
         ebias_ff  <= ebias_in;
         pay_ff    <= man_w[50:29];
         q_ff      <= q_in;
         guard_ff  <= guard_in;
         sticky_ff <= sticky_in;
      end
   end

   // round and pack
   logic [24:0] qr_w;
   logic [31:0] res_in;
   always_comb begin
      qr_w = q_ff + 25'(guard_ff & (sticky_ff | q_ff[0]));
      case (cls_ff)
         CL_ZERO: res_in = {sign_ff, 31'd0};
         CL_INF:  res_in = {sign_ff, 31'd0} | F32_INF;
         CL_NAN:  res_in = {sign_ff, 31'd0} | F32_QNAN | {10'd0, pay_ff};
         default: res_in = {sign_ff, 31'd0} |
                  (norm_ff ? 32'({1'b0, ebias_ff, 23'd0} + {7'd0, qr_w})
                           : {7'd0, qr_w});
      endcase
   end

   always_ff @(posedge clock) begin
      if (en_b) result <= res_in;
   end
endmodule

// ----- rtl/pcm_sample_format_converter.sv -----
// ---------------------------------------------------------------------------
// pcm_sample_format_converter
// Converts raw pcm samples to left-justified s32 or ieee single bits.
// ---------------------------------------------------------------------------
//  channel | ports        | handshake
//  request | req_*        | start & !busy
//  result  | rsp_*        | rsp_valid, one cycle, no back pressure
//  config  | csr_*        | csr_valid & csr_ready
//
// one sample per cycle, through the order, narrow and round stages.
// busy is always low: results cannot be held off, so nothing stalls.
// synchronous reset clears the stage valids and loads the config register defaults.
// ---------------------------------------------------------------------------
module pcm_sample_format_converter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [pcmfc_pkg::RAW_WIDTH-1:0]   req_raw_sample,
   input  logic                              req_frame_end,
   output logic                              rsp_valid,
   output logic [pcmfc_pkg::OUT_WIDTH-1:0]   rsp_sample_bits,
   output logic                              rsp_is_float,
   output logic                              rsp_format_error,
   output logic                              rsp_frame_end_out,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pcmfc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pcmfc_pkg::CSR_DATA_W-1:0]  csr_data
);
   import pcmfc_pkg::*;

   logic [3:0] width_ff;
   logic [1:0] enc_ff;
   logic       be_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 4'd2;
         enc_ff   <= ENC_SIGNED;
         be_ff    <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_WIDTH:    width_ff <= csr_data;
            CSR_ENCODING: enc_ff   <= csr_data[1:0];
            CSR_ENDIAN:   be_ff    <= csr_data[0];
            default: ;
         endcase
      end
   end

   // stage one: byte order and kind
   logic [63:0] ord_in;
   kind_type    kind_in;
   always_comb begin
      ord_in = 64'd0;
      kind_in = KIND_ERR;
      if (enc_ff <= ENC_UNSIGNED && width_ff >= 4'd1 && width_ff <= 4'd4)
         kind_in = KIND_INT;
      else if (enc_ff == ENC_FLOAT && width_ff == 4'd4) kind_in = KIND_F32;
      else if (enc_ff == ENC_FLOAT && width_ff == 4'd8) kind_in = KIND_F64;
      if (width_ff <= 4'd8) begin
         for (int i = 0; i < 8; i++) begin
            if (be_ff) begin
               if (i < int'(width_ff))
                  ord_in[8*(int'(width_ff)-1-i) +: 8] = req_raw_sample[8*i +: 8];
            end else if (i < int'(width_ff)) begin
               ord_in[8*i +: 8] = req_raw_sample[8*i +: 8];
            end
         end
      end
   end

   logic [LATENCY-1:0] vld_ff;
   logic [LATENCY-1:0] fe_ff;
   kind_type    kind1_ff, kind2_ff;
   logic [63:0] ord_ff;
   logic [31:0] simple2_ff, simple_in;
   logic [3:0]  w1_ff;
   logic        uns1_ff;
   logic [31:0] narrow_w;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else vld_ff <= {vld_ff[LATENCY-2:0], start && !busy};
   end

   always_ff @(posedge clock) begin
      fe_ff <= {fe_ff[LATENCY-2:0], req_frame_end};
      if (start && !busy) begin
         ord_ff   <= ord_in;
         kind1_ff <= kind_in;
         w1_ff    <= width_ff;
         uns1_ff  <= (enc_ff == ENC_UNSIGNED);
      end
   end

   // stage two: integer justify and float pass
   always_comb begin
      simple_in = 32'd0;
      case (kind1_ff)
         KIND_INT: begin
            simple_in = ord_ff[31:0] << (6'd32 - {w1_ff[2:0], 3'd0});
            if (uns1_ff) simple_in = simple_in ^ SIGN_BIT;
         end
         KIND_F32: simple_in = ord_ff[31:0];
         default:  simple_in = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (vld_ff[0]) begin
         simple2_ff <= simple_in;
         kind2_ff   <= kind1_ff;
      end
   end

   pcmfc_narrow u_narrow (
      .clock  (clock),
      .en_a   (vld_ff[0]),
      .en_b   (vld_ff[1]),
      .dbl    (ord_ff),
      .result (narrow_w)
   );

   // stage three: output register
   kind_type    kind3_ff;
   logic [31:0] simple3_ff;
   always_ff @(posedge clock) begin
      if (vld_ff[1]) begin
         kind3_ff   <= kind2_ff;
         simple3_ff <= simple2_ff;
      end
   end

   assign rsp_valid         = vld_ff[LATENCY-1];
   assign rsp_sample_bits   = (kind3_ff == KIND_F64) ? narrow_w : simple3_ff;
   assign rsp_is_float      = (kind3_ff == KIND_F32) || (kind3_ff == KIND_F64);
   assign rsp_format_error  = (kind3_ff == KIND_ERR);
   assign rsp_frame_end_out = fe_ff[LATENCY-1];

   // checks
   a_lat: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##3 rsp_valid) else $error("result lost");
   a_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_format_error |-> rsp_sample_bits == 32'd0 && !rsp_is_float)
      else $error("error result not zero");
   a_spur: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(vld_ff[1])) else $error("spurious result");
endmodule
